// ===== hw/rtl/mnte_pkg.sv =====
// Shared types and constants for the MIDI note track encoder.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package mnte_pkg;

    localparam int TICK_BITS  = 32;
    localparam int TPS_BITS   = 10;
    localparam int GATE_BITS  = 7;
    localparam int PROD_BITS  = TPS_BITS + GATE_BITS;
    localparam int VLQ_GROUPS = (TICK_BITS + 6) / 7;
    localparam int GRP_BITS   = $clog2(VLQ_GROUPS);

    // floor(x / 100) == (x * DIV_RECIP) >> DIV_SHIFT for every x below 2^PROD_BITS
    localparam int DIV_SHIFT  = 24;
    localparam int RECIP_BITS = 18;
    localparam logic [RECIP_BITS-1:0] DIV_RECIP = 18'd167773;

    localparam logic [TPS_BITS-1:0]  TPS_RESET = 10'd120;
    localparam logic [GATE_BITS-1:0] GATE_MAX  = 7'd100;
    localparam logic [GATE_BITS-1:0] GATE_MIN  = 7'd1;

    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] META_EVENT  = 8'hFF;
    localparam logic [7:0] META_EOT    = 8'h2F;

    localparam logic CMD_STEP   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic signed [7:0] note;
        logic [6:0]        velocity;
        logic [7:0]        step_gate;
        logic [7:0]        default_gate;
        logic              instrument_ok;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_word_t;

    typedef enum logic [3:0] {
        BSEL_DELTA,
        BSEL_OFF_STATUS,
        BSEL_ON_STATUS,
        BSEL_OFF_KEY,
        BSEL_ON_KEY,
        BSEL_ON_VEL,
        BSEL_ZERO,
        BSEL_META,
        BSEL_EOT
    } byte_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV,
        ST_OFF_PREP,
        ST_OFF_DELTA,
        ST_OFF_STATUS,
        ST_OFF_KEY,
        ST_OFF_VEL,
        ST_ON_PREP,
        ST_ON_DELTA,
        ST_ON_STATUS,
        ST_ON_KEY,
        ST_ON_VEL,
        ST_EOT
    } state_t;

    typedef struct packed {
        logic      load;
        logic      advance;
        logic      mul;
        logic      div;
        logic      prep_off;
        logic      prep_on;
        logic      next_grp;
        logic      emit;
        byte_sel_t sel;
        logic      last;
        logic      flush_off;
        logic      arm_off;
        logic      clear;
    } dp_cmd_t;

    typedef struct packed {
        logic finish;
        logic sounding;
        logic off_pending;
        logic grp_zero;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mnte_ctrl.sv =====
// Sequencing state machine of the MIDI note track encoder.
// Depends on mnte_pkg; drives the datapath by dp_cmd_t, reads dp_status_t.
`default_nettype none

module mnte_ctrl
    import mnte_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t st,
    output dp_cmd_t         cmd
);

    state_t     state_reg, state_next;
    logic [1:0] eot_reg, eot_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            eot_reg   <= '0;
        end else begin
            state_reg <= state_next;
            eot_reg   <= eot_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        eot_next   = eot_reg;
        cmd        = '0;
        cmd.sel    = BSEL_ZERO;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                eot_next = '0;
                if (st.finish) begin
                    state_next = st.off_pending ? ST_OFF_PREP : ST_EOT;
                end else if (st.sounding) begin
                    state_next = ST_MUL;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = st.off_pending ? ST_OFF_PREP : ST_ON_PREP;
            end
            ST_OFF_PREP: begin
                cmd.prep_off = 1'b1;
                state_next   = ST_OFF_DELTA;
            end
            ST_OFF_DELTA: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = BSEL_DELTA;
                    if (st.grp_zero) begin
                        state_next = ST_OFF_STATUS;
                    end else begin
                        cmd.next_grp = 1'b1;
                    end
                end
            end
            ST_OFF_STATUS: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = BSEL_OFF_STATUS;
                    state_next = ST_OFF_KEY;
                end
            end
            ST_OFF_KEY: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = BSEL_OFF_KEY;
                    state_next = ST_OFF_VEL;
                end
            end
            ST_OFF_VEL: begin
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.sel       = BSEL_ZERO;
                    cmd.flush_off = 1'b1;
                    state_next    = st.finish ? ST_EOT : ST_ON_PREP;
                end
            end
            ST_ON_PREP: begin
                cmd.prep_on = 1'b1;
                state_next  = ST_ON_DELTA;
            end
            ST_ON_DELTA: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = BSEL_DELTA;
                    if (st.grp_zero) begin
                        state_next = ST_ON_STATUS;
                    end else begin
                        cmd.next_grp = 1'b1;
                    end
                end
            end
            ST_ON_STATUS: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = BSEL_ON_STATUS;
                    state_next = ST_ON_KEY;
                end
            end
            ST_ON_KEY: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = BSEL_ON_KEY;
                    state_next = ST_ON_VEL;
                end
            end
            ST_ON_VEL: begin
                if (st.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.sel     = BSEL_ON_VEL;
                    cmd.last    = 1'b1;
                    cmd.arm_off = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_EOT: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    eot_next = eot_reg + 2'd1;
                    unique case (eot_reg)
                        2'd0: cmd.sel = BSEL_ZERO;
                        2'd1: cmd.sel = BSEL_META;
                        2'd2: cmd.sel = BSEL_EOT;
                        default: begin
                            cmd.sel    = BSEL_ZERO;
                            cmd.last   = 1'b1;
                            cmd.clear  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> st.out_free)
        else $error("byte emitted while output register is full");

    a_on_after_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.prep_on |-> !st.off_pending)
        else $error("note-on started with a note-off still pending");

    a_arm_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.arm_off |=> st.off_pending)
        else $error("note-on did not leave a pending note-off");

    a_clear_drops_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> !st.off_pending)
        else $error("end of track left a pending note-off");

endmodule

`default_nettype wire

// ===== hw/rtl/mnte_dp.sv =====
// Datapath of the MIDI note track encoder: timing state, note length,
// delta groups and output register. Depends on mnte_pkg.
`default_nettype none

module mnte_dp
    import mnte_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [TPS_BITS-1:0] cfg_data,
    input  wire in_word_t            s_data,
    input  wire dp_cmd_t             cmd,
    output dp_status_t               st,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_word_t                m_data
);

    logic [TPS_BITS-1:0]         tps_reg;
    in_word_t                    in_reg;
    logic [PROD_BITS-1:0]        prod_reg;
    logic [TPS_BITS-1:0]         dur_reg;
    logic [TICK_BITS-1:0]        step_start_reg;
    logic [TICK_BITS-1:0]        last_tick_reg;
    logic                        off_pending_reg;
    logic [6:0]                  off_note_reg;
    logic [TICK_BITS-1:0]        off_tick_reg;
    logic [VLQ_GROUPS*7-1:0]     delta_reg;
    logic [GRP_BITS-1:0]         grp_reg;
    out_word_t                   out_reg;
    logic                        out_valid_reg;

    logic [7:0]                  gate_raw;
    logic [GATE_BITS-1:0]        gate;
    logic [PROD_BITS+RECIP_BITS-1:0] quo_full;
    logic [TPS_BITS-1:0]         quo;
    logic [TICK_BITS-1:0]        ev_tick;
    logic [VLQ_GROUPS*7-1:0]     delta_new;
    logic [GRP_BITS-1:0]         grp_new;
    logic [6:0]                  grp_arr [VLQ_GROUPS];
    logic [7:0]                  byte_val;
    logic                        out_free;

    assign cfg_ready = 1'b1;

    always_comb begin
        gate_raw = (in_reg.step_gate != 8'd0) ? in_reg.step_gate : in_reg.default_gate;
        if (gate_raw == 8'd0) begin
            gate = GATE_MIN;
        end else if (gate_raw > {1'b0, GATE_MAX}) begin
            gate = GATE_MAX;
        end else begin
            gate = gate_raw[GATE_BITS-1:0];
        end
    end

    assign quo_full = prod_reg * DIV_RECIP;
    assign quo      = quo_full[DIV_SHIFT +: TPS_BITS];

    always_comb begin
        ev_tick   = cmd.prep_off ? off_tick_reg : step_start_reg;
        delta_new = {{(VLQ_GROUPS*7-TICK_BITS){1'b0}}, ev_tick - last_tick_reg};
        grp_new   = '0;
        for (int g = 1; g < VLQ_GROUPS; g++) begin
            if ((delta_new >> (7 * g)) != '0) begin
                grp_new = GRP_BITS'(g);
            end
        end
    end

    always_comb begin
        for (int g = 0; g < VLQ_GROUPS; g++) begin
            grp_arr[g] = delta_reg[7*g +: 7];
        end
    end

    always_comb begin
        case (cmd.sel)
            BSEL_DELTA:      byte_val = {grp_reg != '0, grp_arr[grp_reg]};
            BSEL_OFF_STATUS: byte_val = ST_NOTE_OFF;
            BSEL_ON_STATUS:  byte_val = ST_NOTE_ON;
            BSEL_OFF_KEY:    byte_val = {1'b0, off_note_reg};
            BSEL_ON_KEY:     byte_val = {1'b0, in_reg.note[6:0]};
            BSEL_ON_VEL:     byte_val = {1'b0, in_reg.velocity};
            BSEL_META:       byte_val = META_EVENT;
            BSEL_EOT:        byte_val = META_EOT;
            default:         byte_val = 8'h00;
        endcase
    end

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg         <= TPS_RESET;
            step_start_reg  <= '0;
            last_tick_reg   <= '0;
            off_pending_reg <= 1'b0;
            off_note_reg    <= '0;
            off_tick_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                tps_reg <= (cfg_data == '0) ? TPS_BITS'(1) : cfg_data;
            end
            if (cmd.advance) begin
                step_start_reg <= step_start_reg + TICK_BITS'(tps_reg);
            end
            if (cmd.prep_off || cmd.prep_on) begin
                last_tick_reg <= ev_tick;
            end
            if (cmd.flush_off) begin
                off_pending_reg <= 1'b0;
            end
            if (cmd.arm_off) begin
                off_pending_reg <= 1'b1;
                off_note_reg    <= in_reg.note[6:0];
                off_tick_reg    <= step_start_reg + TICK_BITS'(dur_reg);
                step_start_reg  <= step_start_reg + TICK_BITS'(tps_reg);
            end
            if (cmd.clear) begin
                step_start_reg  <= '0;
                last_tick_reg   <= '0;
                off_pending_reg <= 1'b0;
                off_note_reg    <= '0;
                off_tick_reg    <= '0;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.mul) begin
            prod_reg <= tps_reg * gate;
        end
        if (cmd.div) begin
            dur_reg <= (quo == '0) ? TPS_BITS'(1) : quo;
        end
        if (cmd.prep_off || cmd.prep_on) begin
            delta_reg <= delta_new;
            grp_reg   <= grp_new;
        end else if (cmd.next_grp) begin
            grp_reg <= grp_reg - GRP_BITS'(1);
        end
        if (cmd.emit) begin
            out_reg.out_byte    <= byte_val;
            out_reg.last_of_run <= cmd.last;
        end
    end

    assign st.finish      = (in_reg.cmd == CMD_FINISH);
    assign st.sounding    = (in_reg.cmd == CMD_STEP) && in_reg.instrument_ok
                            && !in_reg.note[7] && (in_reg.velocity != 7'd0);
    assign st.off_pending = off_pending_reg;
    assign st.grp_zero    = (grp_reg == '0);
    assign st.out_free    = out_free;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/midi_note_track_encoder.sv =====
// Top level of the MIDI note track encoder: state machine plus datapath.
// Depends on mnte_pkg, mnte_ctrl and mnte_dp.
//
//   channel   direction  handshake              word
//   s_        in         s_valid / s_ready      in_word_t, one step or finish
//   m_        out        m_valid / m_ready      out_word_t, one track byte
//   cfg_      in         cfg_valid / cfg_ready  ticks of one step, always ready
//
// A silent step is accepted, then decoded and advanced.
// A sounding step passes decode, multiply and divide, then issues 4 to 8 bytes,
// or 8 to 16 bytes with a pending note-off; at most one byte issues a cycle.
// Finish passes decode, an optional note-off (prepare plus 4..8 bytes), then 4 bytes.
// A stalled m_ready holds the sequencer; the next word is taken only in idle.
// Reset is synchronous on aresetn low and needs no clearing pass.
`default_nettype none

module midi_note_track_encoder
    import mnte_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [TPS_BITS-1:0] cfg_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_word_t            s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_word_t                m_data
);

    dp_cmd_t    cmd;
    dp_status_t st;

    mnte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    mnte_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .st        (st),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== sim/tb_midi_note_track_encoder.sv =====
// Self-checking bench for midi_note_track_encoder: directed steps, then random timelines
// under several tick rates and idling patterns, compared byte by byte with a local encoder.
// Depends on mnte_pkg and the encoder RTL.
`default_nettype none

module tb_midi_note_track_encoder;
    import mnte_pkg::*;

    localparam int REST          = -1;
    localparam int PERCENT       = 100;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 40;
    localparam int PLAN_ROWS     = 24;
    localparam int RUN_LIMIT     = 5000000;

    typedef struct packed {
        in_word_t    word;
        logic        typed;
        logic [3:0]  n;
        logic [63:0] bytes;
    } plan_row_t;

    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic            cfg_valid = 1'b0;
    logic [TPS_BITS-1:0] cfg_data = '0;
    logic            s_valid   = 1'b0;
    in_word_t        s_data    = '0;
    logic            m_ready   = 1'b0;
    logic            cfg_ready;
    logic            s_ready;
    logic            m_valid;
    out_word_t       m_data;

    int unsigned          tick_rate       = TPS_RESET;
    logic [TICK_BITS-1:0] next_step_tick  = '0;
    logic [TICK_BITS-1:0] last_event_tick = '0;
    logic                 off_armed       = 1'b0;
    logic [6:0]           off_key         = '0;
    logic [TICK_BITS-1:0] off_at          = '0;

    logic [7:0] step_bytes [$];
    out_word_t  track_bytes_due [$];
    plan_row_t  plan [PLAN_ROWS];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int items_sent    = 0;
    int bytes_checked = 0;

    midi_note_track_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #6 aclk = ~aclk;

    initial begin
        #RUN_LIMIT;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at %0t: %s, got %0h, expected %0h", $time, what, got, want);
    endtask

    function automatic in_word_t step_word(logic c, int key, int vel, int sg, int dg, logic ok);
        in_word_t w;
        w.cmd           = c;
        w.note          = 8'(key);
        w.velocity      = 7'(vel);
        w.step_gate     = 8'(sg);
        w.default_gate  = 8'(dg);
        w.instrument_ok = ok;
        return w;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int pick;
        pick            = $urandom_range(99);
        w.cmd           = CMD_STEP;
        w.note          = 8'($urandom_range(127));
        w.velocity      = 7'($urandom_range(127, 1));
        w.step_gate     = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(255));
        w.default_gate  = 8'($urandom_range(255));
        w.instrument_ok = 1'b1;
        if (pick < 5) begin
            w.cmd = CMD_FINISH;
        end else if (pick < 15) begin
            w.note = 8'(REST);
        end else if (pick < 25) begin
            w.note          = 8'($urandom_range(255));
            w.velocity      = 7'($urandom_range(127));
            w.instrument_ok = 1'($urandom_range(1));
        end
        return w;
    endfunction

    function automatic void put_event(logic [TICK_BITS-1:0] at, logic [7:0] status,
                                      logic [6:0] key, logic [6:0] vel);
        logic [TICK_BITS-1:0] remain;
        logic [7:0]           grp [VLQ_GROUPS];
        int                   n;
        remain = at - last_event_tick;
        grp[0] = {1'b0, remain[6:0]};
        n      = 1;
        remain = remain >> 7;
        while (remain != 0 && n < VLQ_GROUPS) begin
            grp[n] = {1'b1, remain[6:0]};
            n++;
            remain = remain >> 7;
        end
        for (int i = n - 1; i >= 0; i--) step_bytes.push_back(grp[i]);
        last_event_tick = at;
        step_bytes.push_back(status);
        step_bytes.push_back({1'b0, key});
        step_bytes.push_back({1'b0, vel});
    endfunction

    function automatic void flush_note_off();
        if (off_armed) begin
            put_event(off_at, ST_NOTE_OFF, off_key, 7'd0);
            off_armed = 1'b0;
        end
    endfunction

    function automatic void encode_step(in_word_t w);
        int unsigned gate;
        int unsigned len;
        step_bytes.delete();
        if (w.cmd == CMD_FINISH) begin
            flush_note_off();
            step_bytes.push_back(8'h00);
            step_bytes.push_back(META_EVENT);
            step_bytes.push_back(META_EOT);
            step_bytes.push_back(8'h00);
            next_step_tick  = '0;
            last_event_tick = '0;
            off_armed       = 1'b0;
            off_key         = '0;
            off_at          = '0;
        end else begin
            if (w.instrument_ok && !w.note[7] && w.velocity != 0) begin
                gate = (w.step_gate != 0) ? w.step_gate : w.default_gate;
                if (gate < GATE_MIN) gate = GATE_MIN;
                if (gate > GATE_MAX) gate = GATE_MAX;
                len = (tick_rate * gate) / PERCENT;
                if (len < 1) len = 1;
                flush_note_off();
                put_event(next_step_tick, ST_NOTE_ON, w.note[6:0], w.velocity);
                off_armed = 1'b1;
                off_key   = w.note[6:0];
                off_at    = next_step_tick + len;
            end
            next_step_tick = next_step_tick + tick_rate;
        end
    endfunction

    task automatic issue(input in_word_t w, input logic typed = 1'b0, input int n = 0,
                         input logic [63:0] bytes = '0);
        out_word_t due;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        encode_step(w);
        if (typed) begin
            step_bytes.delete();
            for (int k = 0; k < n; k++) step_bytes.push_back(bytes[8*(n-1-k) +: 8]);
        end
        foreach (step_bytes[k]) begin
            due.out_byte    = step_bytes[k];
            due.last_of_run = (k == step_bytes.size() - 1);
            track_bytes_due.push_back(due);
        end
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (track_bytes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tick_rate(input logic [TPS_BITS-1:0] rate);
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        do @(posedge aclk); while (!cfg_ready);
        tick_rate = (rate == 0) ? 1 : rate;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin : take_bytes
        out_word_t due;
        if (aresetn && m_valid && m_ready) begin
            if (track_bytes_due.size() == 0) begin
                report_mismatch("byte with none due", m_data.out_byte, 0);
            end else begin
                due = track_bytes_due.pop_front();
                bytes_checked++;
                if (m_data.out_byte !== due.out_byte)
                    report_mismatch("out_byte", m_data.out_byte, due.out_byte);
                if (m_data.last_of_run !== due.last_of_run)
                    report_mismatch("last_of_run", m_data.last_of_run, due.last_of_run);
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    initial begin : run
        logic [TPS_BITS-1:0] tick_plan [PHASES];
        int sent;
        int burst;

        plan = '{
            '{step_word(CMD_FINISH, 0, 0, 0, 0, 0), 1'b1, 4'd4,
              {8'h00, META_EVENT, META_EOT, 8'h00}},
            '{step_word(CMD_STEP, 60, 100, 50, 0, 1), 1'b1, 4'd4,
              {8'h00, ST_NOTE_ON, 8'd60, 8'd100}},
            '{step_word(CMD_STEP, REST, 127, 50, 50, 1), 1'b1, 4'd0, 64'h0},
            '{step_word(CMD_STEP, 127, 127, 0, 0, 1), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_STEP, -128, 127, 50, 50, 1), 1'b1, 4'd0, 64'h0},
            '{step_word(CMD_STEP, 64, 0, 50, 50, 1), 1'b1, 4'd0, 64'h0},
            '{step_word(CMD_STEP, 64, 127, 50, 50, 0), 1'b1, 4'd0, 64'h0},
            '{step_word(CMD_FINISH, 0, 0, 0, 0, 0), 1'b1, 4'd8,
              {8'h01, ST_NOTE_OFF, 8'h7f, 8'h00, 8'h00, META_EVENT, META_EOT, 8'h00}},
            '{step_word(CMD_STEP, 0, 1, 255, 0, 1), 1'b1, 4'd4,
              {8'h00, ST_NOTE_ON, 8'h00, 8'h01}},
            '{step_word(CMD_STEP, 1, 127, 0, 255, 1), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_STEP, 127, 64, 1, 200, 1), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_STEP, 42, 99, 100, 1, 1), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_STEP, 17, 33, 101, 0, 1), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_STEP, REST, 0, 0, 0, 0), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_STEP, 127, 127, 255, 255, 1), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_STEP, -2, 127, 50, 50, 1), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_FINISH, 0, 0, 0, 0, 0), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_FINISH, 0, 0, 0, 0, 0), 1'b1, 4'd4,
              {8'h00, META_EVENT, META_EOT, 8'h00}},
            '{step_word(CMD_STEP, 0, 127, 0, 0, 0), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_STEP, 100, 50, 0, 50, 1), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_STEP, REST, 127, 0, 0, 1), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_STEP, REST, 127, 0, 0, 1), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_STEP, 5, 5, 99, 0, 1), 1'b0, 4'd0, 64'h0},
            '{step_word(CMD_FINISH, 0, 0, 0, 0, 0), 1'b0, 4'd0, 64'h0}
        };
        tick_plan = '{10'd1023, 10'd0, 10'd1, TPS_RESET, 10'd0, 10'd99, 10'd0, 10'd1023};
        tick_plan[4] = 10'($urandom_range(1022, 2));
        tick_plan[6] = 10'($urandom_range(1022, 2));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
            issue(plan[i].word, plan[i].typed, plan[i].n, plan[i].bytes);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 88;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 88;
                end
                default: begin
                    send_idle_pct = 17;
                    stall_pct     = 17;
                end
            endcase
            write_tick_rate(tick_plan[p]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(39) == 0) begin
                    burst = $urandom_range(24, 12);
                    repeat (burst) issue(step_word(CMD_STEP, REST, 127, 0, 0, 1));
                    sent += burst;
                end else begin
                    issue(random_word());
                    sent++;
                end
            end
            drain();
        end

        if (track_bytes_due.size() != 0)
            report_mismatch("bytes never delivered", track_bytes_due.size(), 0);
        $display("covered %0d step and finish words over %0d tick-rate phases and four idling",
                 items_sent, PHASES);
        $display("compared %0d track bytes, %0d mismatches", bytes_checked, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== midi_note_track_encoder.f =====
hw/rtl/mnte_pkg.sv
hw/rtl/mnte_ctrl.sv
hw/rtl/mnte_dp.sv
hw/rtl/midi_note_track_encoder.sv
sim/tb_midi_note_track_encoder.sv
